// ----- rtl/elf_chk_pkg.sv -----
package elf_chk_pkg;

	localparam int IN_DATA_W  = 336;
	localparam int OUT_DATA_W = 40;
	localparam int WORD_W     = 32;
	localparam int CFG_ADDR_W = 2;

	localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_SIZE = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_ZONE_LOW   = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_ZONE_HIGH  = 2'd2;

	localparam logic CMD_HEADER  = 1'b0;
	localparam logic CMD_SEGMENT = 1'b1;

	localparam logic [31:0] ELF_MAGIC     = 32'h464C_457F;
	localparam logic [15:0] ELF_CLASS_ENC = 16'h0101;
	localparam logic [15:0] TYPE_EXEC     = 16'd2;
	localparam logic [15:0] MACH_386      = 16'd3;
	localparam logic [31:0] HDR_BYTES     = 32'd52;
	localparam logic [15:0] PH_BYTES      = 16'd32;
	localparam int          PH_SHIFT      = 5;
	localparam logic [31:0] PTYPE_LOAD    = 32'd1;

	typedef enum logic [3:0] {
		STAT_OK      = 4'd0,
		STAT_MAGIC   = 4'd1,
		STAT_CLASS   = 4'd2,
		STAT_TYPE    = 4'd3,
		STAT_MACHINE = 4'd4,
		STAT_HEADERS = 4'd5,
		STAT_NOSEG   = 4'd6,
		STAT_SEGWIN  = 4'd7,
		STAT_ENTWIN  = 4'd8
	} status_t;

	// packed MSB first: last field of the word sits on top
	typedef struct packed {
		logic [31:0] seg_memsz;
		logic [31:0] seg_filesz;
		logic [31:0] seg_vaddr;
		logic [31:0] seg_offset;
		logic [31:0] seg_type;
		logic [31:0] entsize_count;
		logic [31:0] table_offset;
		logic [31:0] entry_point;
		logic [31:0] type_machine;
		logic [47:0] ident_prefix;
	} item_t;

	typedef struct packed {
		logic    fail;
		status_t code;
	} hdr_res_t;

	typedef struct packed {
		logic is_load;
		logic range_err;
		logic win_err;
	} seg_res_t;

endpackage

// ----- rtl/elf32_image_checker_core.sv -----
// Pipeline: input reg, then result reg; the checks between them are combinational on the input reg.
// Throughput: one word per cycle unless m_tready holds the result reg full; checks are single-pass adds and compares.
// Each input word yields exactly one result word.
// Reset (arst_n low, async): pipeline empties, verdict state and config registers clear to zero.
module elf32_image_checker_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// ident_prefix, type_machine, entry_point, table_offset, entsize_count,
	// seg_type, seg_offset, seg_vaddr, seg_filesz, seg_memsz
	input  logic [elf_chk_pkg::IN_DATA_W-1:0]     s_tdata,
	// cmd
	input  logic [0:0]                            s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// status[3:0], load_entry[35:4], zero pad
	output logic [elf_chk_pkg::OUT_DATA_W-1:0]    m_tdata,
	// done_res
	output logic [0:0]                            m_tuser,
	input  logic                                  cfg_we,
	input  logic [elf_chk_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [elf_chk_pkg::WORD_W-1:0]        cfg_data
);

	logic [31:0]          image_size_q, zone_low_q, zone_high_q;
	logic                 valid_s1;
	logic                 cmd_s1;
	elf_chk_pkg::item_t   item_s1;
	logic                 advance;
	elf_chk_pkg::hdr_res_t hdr_res;
	elf_chk_pkg::seg_res_t seg_res;
	elf_chk_pkg::status_t  res_status;
	logic                 res_done;
	logic [31:0]          res_entry;
	logic                 out_valid_q;
	elf_chk_pkg::status_t  status_q;
	logic                 done_q;
	logic [31:0]          entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_size_q <= 32'd0;
			zone_low_q   <= 32'd0;
			zone_high_q  <= 32'd0;
		end else if (cfg_we) begin
			case (cfg_addr)
				elf_chk_pkg::CFG_IMAGE_SIZE: image_size_q <= cfg_data;
				elf_chk_pkg::CFG_ZONE_LOW:   zone_low_q   <= cfg_data;
				elf_chk_pkg::CFG_ZONE_HIGH:  zone_high_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1 moves on when the result register is free or being drained
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= elf_chk_pkg::item_t'(s_tdata);
			cmd_s1  <= s_tuser[0];
		end
	end

	elf_chk_hdr u_hdr (
		.ident_prefix (item_s1.ident_prefix),
		.type_machine (item_s1.type_machine),
		.table_offset (item_s1.table_offset),
		.entsize_count(item_s1.entsize_count),
		.image_size   (image_size_q),
		.res          (hdr_res)
	);

	elf_chk_seg u_seg (
		.seg_type  (item_s1.seg_type),
		.seg_offset(item_s1.seg_offset),
		.seg_vaddr (item_s1.seg_vaddr),
		.seg_filesz(item_s1.seg_filesz),
		.seg_memsz (item_s1.seg_memsz),
		.image_size(image_size_q),
		.zone_low  (zone_low_q),
		.zone_high (zone_high_q),
		.res       (seg_res)
	);

	elf_chk_state u_state (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (valid_s1 && advance),
		.cmd        (cmd_s1),
		.hdr        (hdr_res),
		.seg        (seg_res),
		.entry_point(item_s1.entry_point),
		.ent_count  (item_s1.entsize_count[31:16]),
		.zone_low   (zone_low_q),
		.zone_high  (zone_high_q),
		.res_status (res_status),
		.res_done   (res_done),
		.res_entry  (res_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			status_q <= res_status;
			done_q   <= res_done;
			entry_q  <= res_entry;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, entry_q, status_q};
	assign m_tuser  = done_q;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && out_valid_q && !m_tready))
		else $error("input stalled with room in the pipeline");

	a_open_word_is_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !done_q) |-> (status_q == elf_chk_pkg::STAT_OK && entry_q == 32'd0))
		else $error("non-final result carries data");

	a_fail_hides_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != elf_chk_pkg::STAT_OK) |-> (entry_q == 32'd0 && done_q))
		else $error("failed verdict exposes entry address");

endmodule

// ----- rtl/elf_chk_hdr.sv -----
module elf_chk_hdr (
	input  logic [47:0]                   ident_prefix,
	input  logic [31:0]                   type_machine,
	input  logic [31:0]                   table_offset,
	input  logic [31:0]                   entsize_count,
	input  logic [elf_chk_pkg::WORD_W-1:0] image_size,
	output elf_chk_pkg::hdr_res_t          res
);

	logic [15:0] ent_size;
	logic [15:0] ent_count;
	logic [32:0] table_end;

	assign ent_size  = entsize_count[15:0];
	assign ent_count = entsize_count[31:16];
	// entry size is known to be 32 once this sum matters
	assign table_end = {1'b0, table_offset}
		+ {12'd0, ent_count, {elf_chk_pkg::PH_SHIFT{1'b0}}};

	always_comb begin
		res.fail = 1'b1;
		res.code = elf_chk_pkg::STAT_OK;
		if (image_size < elf_chk_pkg::HDR_BYTES
			|| ident_prefix[31:0] != elf_chk_pkg::ELF_MAGIC) begin
			res.code = elf_chk_pkg::STAT_MAGIC;
		end else if (ident_prefix[47:32] != elf_chk_pkg::ELF_CLASS_ENC) begin
			res.code = elf_chk_pkg::STAT_CLASS;
		end else if (type_machine[15:0] != elf_chk_pkg::TYPE_EXEC) begin
			res.code = elf_chk_pkg::STAT_TYPE;
		end else if (type_machine[31:16] != elf_chk_pkg::MACH_386) begin
			res.code = elf_chk_pkg::STAT_MACHINE;
		end else if (ent_count == 16'd0 || ent_size != elf_chk_pkg::PH_BYTES) begin
			res.code = elf_chk_pkg::STAT_NOSEG;
		end else if (table_end > {1'b0, image_size}) begin
			res.code = elf_chk_pkg::STAT_HEADERS;
		end else begin
			res.fail = 1'b0;
		end
	end

endmodule

// ----- rtl/elf_chk_seg.sv -----
module elf_chk_seg (
	input  logic [31:0]          seg_type,
	input  logic [31:0]          seg_offset,
	input  logic [31:0]          seg_vaddr,
	input  logic [31:0]          seg_filesz,
	input  logic [31:0]          seg_memsz,
	input  logic [31:0]          image_size,
	input  logic [31:0]          zone_low,
	input  logic [31:0]          zone_high,
	output elf_chk_pkg::seg_res_t res
);

	logic [32:0] file_end;
	logic [32:0] mem_end;

	assign file_end = {1'b0, seg_offset} + {1'b0, seg_filesz};
	assign mem_end  = {1'b0, seg_vaddr} + {1'b0, seg_memsz};

	assign res.is_load   = (seg_type == elf_chk_pkg::PTYPE_LOAD);
	assign res.range_err = (seg_memsz < seg_filesz) || (file_end > {1'b0, image_size});
	assign res.win_err   = (seg_memsz != 32'd0)
		&& ((seg_vaddr < zone_low) || (mem_end > {1'b0, zone_high}));

endmodule

// ----- rtl/elf_chk_state.sv -----
module elf_chk_state (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic                  cmd,
	input  elf_chk_pkg::hdr_res_t hdr,
	input  elf_chk_pkg::seg_res_t seg,
	input  logic [31:0]           entry_point,
	input  logic [15:0]           ent_count,
	input  logic [31:0]           zone_low,
	input  logic [31:0]           zone_high,
	output elf_chk_pkg::status_t  res_status,
	output logic                  res_done,
	output logic [31:0]           res_entry
);

	logic                 header_seen_q, header_seen_d;
	logic                 verdict_final_q, verdict_final_d;
	elf_chk_pkg::status_t verdict_q, verdict_d;
	logic                 window_fault_q, window_fault_d;
	logic [15:0]          entries_expected_q, entries_expected_d;
	logic [15:0]          entries_seen_q, entries_seen_d;
	logic                 any_loadable_q, any_loadable_d;
	logic [31:0]          saved_entry_q, saved_entry_d;

	always_comb begin
		header_seen_d      = header_seen_q;
		verdict_final_d    = verdict_final_q;
		verdict_d          = verdict_q;
		window_fault_d     = window_fault_q;
		entries_expected_d = entries_expected_q;
		entries_seen_d     = entries_seen_q;
		any_loadable_d     = any_loadable_q;
		saved_entry_d      = saved_entry_q;
		if (cmd == elf_chk_pkg::CMD_HEADER) begin
			header_seen_d      = 1'b1;
			verdict_final_d    = hdr.fail;
			verdict_d          = hdr.fail ? hdr.code : elf_chk_pkg::STAT_OK;
			window_fault_d     = 1'b0;
			any_loadable_d     = 1'b0;
			entries_seen_d     = 16'd0;
			entries_expected_d = ent_count;
			saved_entry_d      = entry_point;
		end else if (header_seen_q && !verdict_final_q) begin
			entries_seen_d = entries_seen_q + 16'd1;
			if (seg.is_load) begin
				any_loadable_d = 1'b1;
				if (seg.win_err) begin
					window_fault_d = 1'b1;
				end
			end
			if (seg.is_load && seg.range_err) begin
				verdict_final_d = 1'b1;
				verdict_d       = elf_chk_pkg::STAT_HEADERS;
			end else if (entries_seen_d == entries_expected_q) begin
				verdict_final_d = 1'b1;
				if (!any_loadable_d) begin
					verdict_d = elf_chk_pkg::STAT_NOSEG;
				end else if (window_fault_d) begin
					verdict_d = elf_chk_pkg::STAT_SEGWIN;
				end else if (saved_entry_q < zone_low || saved_entry_q >= zone_high) begin
					verdict_d = elf_chk_pkg::STAT_ENTWIN;
				end else begin
					verdict_d = elf_chk_pkg::STAT_OK;
				end
			end
		end
	end

	// result reflects the state after this word
	assign res_done   = verdict_final_d;
	assign res_status = verdict_final_d ? verdict_d : elf_chk_pkg::STAT_OK;
	assign res_entry  = (verdict_final_d && verdict_d == elf_chk_pkg::STAT_OK)
		? saved_entry_d : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_seen_q      <= 1'b0;
			verdict_final_q    <= 1'b0;
			verdict_q          <= elf_chk_pkg::STAT_OK;
			window_fault_q     <= 1'b0;
			entries_expected_q <= 16'd0;
			entries_seen_q     <= 16'd0;
			any_loadable_q     <= 1'b0;
			saved_entry_q      <= 32'd0;
		end else if (step) begin
			header_seen_q      <= header_seen_d;
			verdict_final_q    <= verdict_final_d;
			verdict_q          <= verdict_d;
			window_fault_q     <= window_fault_d;
			entries_expected_q <= entries_expected_d;
			entries_seen_q     <= entries_seen_d;
			any_loadable_q     <= any_loadable_d;
			saved_entry_q      <= saved_entry_d;
		end
	end

	// an open image never has counted past its table
	a_seen_below_expected: assert property (@(posedge clk) disable iff (!arst_n)
		(header_seen_q && !verdict_final_q) |-> (entries_seen_q < entries_expected_q))
		else $error("entry count ran past table size");

endmodule
